>>> rtl/sfm_pkg.sv
// Shared constants, payload types and codes for the streamed substring search block.
package sfm_pkg;

    localparam int MAX_NEEDLE    = 16;
    localparam int POSITION_BITS = 16;
    localparam int OFFSET_W      = 16;
    localparam int BYTE_W        = 8;

    // Needle length and window fill both count from 0 up to MAX_NEEDLE.
    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

    // The haystack position is held exactly up to POS_SAT, so the start of a
    // match that ends there is still known.
    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;
    localparam longint unsigned POS_SAT = POS_MAX + 64'(MAX_NEEDLE);
    localparam int HPOS_W = $clog2(POS_SAT + 64'd1);

    // Width used to saturate a match offset into the result field.
    localparam int SAT_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

    typedef enum logic {
        OP_NEEDLE = 1'b0,
        OP_HAY    = 1'b1
    } opcode_t;

    typedef logic [BYTE_W-1:0] data_t;

    typedef struct packed {
        opcode_t     opcode;
        data_t       data_byte;
        logic        last;
    } in_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } out_t;

    // Needle as seen by the scanner: the newest needle byte sits at the top
    // index, so the needle lines up with the newest bytes of the window.
    typedef struct packed {
        logic [MAX_NEEDLE-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                  length;
    } needle_t;

endpackage

>>> rtl/sfm_needle.sv
// Needle store: a right-aligned byte shift line with its length and end flag.
module sfm_needle (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              hay,
    input  sfm_pkg::data_t    data_byte,
    input  logic              last,
    output sfm_pkg::needle_t  needle
);

    logic [sfm_pkg::MAX_NEEDLE-1:0][sfm_pkg::BYTE_W-1:0] bytes_reg;
    logic [sfm_pkg::MAX_NEEDLE-1:0][sfm_pkg::BYTE_W-1:0] bytes_next;
    logic [sfm_pkg::LEN_W-1:0] length_reg;
    logic [sfm_pkg::LEN_W-1:0] length_next;
    logic [sfm_pkg::LEN_W-1:0] base_len;
    logic                      done_reg;
    logic                      done_next;
    logic                      room;

    // A byte after a finished needle starts a new one.
    assign base_len = done_reg ? '0 : length_reg;
    assign room     = base_len < sfm_pkg::LEN_W'(sfm_pkg::MAX_NEEDLE);

    always_comb
    begin
        for (int j = 0; j < sfm_pkg::MAX_NEEDLE - 1; j++)
        begin
            bytes_next[j] = bytes_reg[j + 1];
        end
        bytes_next[sfm_pkg::MAX_NEEDLE-1] = data_byte;
    end

    always_comb
    begin
        length_next = length_reg;
        done_next   = done_reg;
        if (load)
        begin
            length_next = room ? base_len + sfm_pkg::LEN_W'(1) : base_len;
            done_next   = last;
        end
        else if (hay)
        begin
            done_next = 1'b1;
        end
    end

    // Bytes beyond the needle capacity are dropped.
    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            done_reg   <= 1'b1;
        end
        else
        begin
            length_reg <= length_next;
            done_reg   <= done_next;
        end
    end

    assign needle.bytes  = bytes_reg;
    assign needle.length = length_reg;

endmodule

>>> rtl/sfm_scan.sv
// Haystack scanner: sliding window, parallel compare and first-match tracking.
module sfm_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              shift,
    input  sfm_pkg::data_t    data_byte,
    input  sfm_pkg::needle_t  needle,
    output sfm_pkg::out_t     result
);

    logic [sfm_pkg::MAX_NEEDLE-1:0][sfm_pkg::BYTE_W-1:0] win_reg;
    logic [sfm_pkg::MAX_NEEDLE-1:0][sfm_pkg::BYTE_W-1:0] win_next;
    logic [sfm_pkg::LEN_W-1:0]          fill_reg;
    logic [sfm_pkg::LEN_W-1:0]          fill_next;
    logic [sfm_pkg::HPOS_W-1:0]         pos_reg;
    logic [sfm_pkg::HPOS_W-1:0]         pos_next;
    logic                               seen_reg;
    logic                               seen_next;
    logic [sfm_pkg::POSITION_BITS-1:0]  moff_reg;
    logic [sfm_pkg::POSITION_BITS-1:0]  moff_next;
    logic [sfm_pkg::MAX_NEEDLE-1:0]     lane_ok;
    logic [sfm_pkg::HPOS_W:0]           start_wide;
    logic                               pos_live;
    logic                               start_ok;
    logic                               match_now;
    logic [sfm_pkg::POSITION_BITS-1:0]  off_full;
    logic [sfm_pkg::SAT_W-1:0]          off_ext;

    always_comb
    begin
        for (int j = 0; j < sfm_pkg::MAX_NEEDLE - 1; j++)
        begin
            win_next[j] = win_reg[j + 1];
        end
        win_next[sfm_pkg::MAX_NEEDLE-1] = data_byte;
    end

    assign fill_next = (fill_reg < sfm_pkg::LEN_W'(sfm_pkg::MAX_NEEDLE))
                     ? fill_reg + sfm_pkg::LEN_W'(1) : fill_reg;

    // Lanes below the needle's start are don't-care.
    always_comb
    begin
        for (int j = 0; j < sfm_pkg::MAX_NEEDLE; j++)
        begin
            lane_ok[j] = (win_next[j] == needle.bytes[j])
                || (({1'b0, needle.length} + (sfm_pkg::LEN_W + 1)'(j))
                    < (sfm_pkg::LEN_W + 1)'(sfm_pkg::MAX_NEEDLE));
        end
    end

    assign pos_live   = pos_reg < sfm_pkg::HPOS_W'(sfm_pkg::POS_SAT);
    assign start_wide = {1'b0, pos_reg} + (sfm_pkg::HPOS_W + 1)'(1)
                      - (sfm_pkg::HPOS_W + 1)'(needle.length);
    assign start_ok   = start_wide <= (sfm_pkg::HPOS_W + 1)'(sfm_pkg::POS_MAX);
    assign match_now  = !seen_reg && (&lane_ok) && (needle.length != '0)
                      && (fill_next >= needle.length) && pos_live && start_ok;

    always_comb
    begin
        off_full = seen_reg ? moff_reg : start_wide[sfm_pkg::POSITION_BITS-1:0];
        off_ext  = sfm_pkg::SAT_W'(off_full);
        result.found = seen_reg || match_now;
        if (!result.found)
        begin
            result.offset = '0;
        end
        else if (off_ext > sfm_pkg::SAT_W'({sfm_pkg::OFFSET_W{1'b1}}))
        begin
            result.offset = '1;
        end
        else
        begin
            result.offset = off_ext[sfm_pkg::OFFSET_W-1:0];
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        seen_next = seen_reg;
        moff_next = moff_reg;
        if (clear)
        begin
            pos_next  = '0;
            seen_next = 1'b0;
            moff_next = '0;
        end
        else if (shift)
        begin
            pos_next  = pos_live ? pos_reg + sfm_pkg::HPOS_W'(1) : pos_reg;
            seen_next = seen_reg || match_now;
            moff_next = match_now ? start_wide[sfm_pkg::POSITION_BITS-1:0] : moff_reg;
        end
    end

    // Stale window bytes are masked by the fill count, so the window needs no reset.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            seen_reg <= 1'b0;
            moff_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                fill_reg <= '0;
            end
            else if (shift)
            begin
                fill_reg <= fill_next;
            end
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            moff_reg <= moff_next;
        end
    end

    a_seen_has_fill: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (fill_reg != '0) && (pos_reg != '0))
        else $error("match recorded with an empty window");

    a_offset_behind_position: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (sfm_pkg::HPOS_W + 1)'(moff_reg) < (sfm_pkg::HPOS_W + 1)'(pos_reg))
        else $error("match offset not behind the scan position");

endmodule

>>> rtl/substring_first_match.sv
// Top level of the streamed first-occurrence substring search block.
//
// Usage: items arrive on the in channel (valid/ready). Opcode OP_NEEDLE items
// load needle bytes, up to MAX_NEEDLE; the byte marked last ends the needle,
// and a later needle byte starts a new one. Opcode OP_HAY items stream the
// haystack. The haystack item marked last produces exactly one transfer on
// the out channel: found, and the offset of the earliest complete match
// (0 when not found, saturated to the field's top). The needle is kept
// for the next haystack; a needle byte in mid-haystack drops the scan.
// Path: an accepted item is held in the input register and processed from
// there; a result is registered in the output register and offered on out.
// Throughput: one item per cycle unless a finished haystack waits on a full
// output register; the window compare lies between the two registers.
// Reset clears the needle length, scan state and both valid flags; the
// input register starts empty, so the block is ready on leaving reset.
// When the receiver stalls, the result holds in the output register; the
// input register keeps taking items until a finished haystack waits in it,
// so items that yield no result keep flowing while the pending result waits.
module substring_first_match (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sfm_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sfm_pkg::out_t  out_data
);

    // Input register.
    logic           s1_valid_reg;
    logic           s1_valid_next;
    sfm_pkg::in_t   s1_data_reg;

    // Result register.
    logic           out_valid_reg;
    logic           out_valid_next;
    sfm_pkg::out_t  out_data_reg;

    logic             in_xfer;
    logic             proc;
    logic             is_hay;
    logic             is_result;
    sfm_pkg::needle_t needle;
    sfm_pkg::out_t    result;

    assign is_hay    = s1_data_reg.opcode == sfm_pkg::OP_HAY;
    assign is_result = is_hay && s1_data_reg.last;

    // An item that yields no result may always proceed; a result needs the
    // output register to be free or being emptied in this cycle.
    assign proc     = s1_valid_reg && (!is_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || proc;
    assign in_xfer  = in_valid && in_ready;

    sfm_needle u_needle (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc && !is_hay),
        .hay       (proc && is_hay),
        .data_byte (s1_data_reg.data_byte),
        .last      (s1_data_reg.last),
        .needle    (needle)
    );

    // The scan is cleared by a needle byte and after every finished haystack.
    sfm_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (proc && (!is_hay || s1_data_reg.last)),
        .shift     (proc && is_hay),
        .data_byte (s1_data_reg.data_byte),
        .needle    (needle),
        .result    (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc && is_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= in_data;
        end
        if (proc && is_result)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.found |-> out_data_reg.offset == '0)
        else $error("offset not zero on a result without a match");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && is_result && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && is_result) |=> out_valid_reg == ($past(out_valid_reg) && !$past(out_ready)))
        else $error("result appeared without a finished haystack");

endmodule

>>> dv/tb_substring_first_match.sv
// Self-checking testbench for the streamed first-occurrence substring search block.
module tb_substring_first_match;
    timeunit 1ns;
    timeprecision 1ps;

    // Largest value that fits the offset field of a result.
    localparam longint unsigned OFFSET_TOP = (64'd1 << sfm_pkg::OFFSET_W) - 64'd1;

    // This class tracks the search as the block should see it. Every accepted
    // input transfer is run through the tracker. A haystack byte marked last
    // queues the one result it must produce. Every output transfer is then
    // compared against the oldest queued result.
    class first_match_board;
        sfm_pkg::data_t                    needle [sfm_pkg::MAX_NEEDLE];
        bit [sfm_pkg::LEN_W-1:0]           needle_len;
        bit                                needle_closed;
        sfm_pkg::data_t                    win [sfm_pkg::MAX_NEEDLE];
        bit [sfm_pkg::LEN_W-1:0]           win_fill;
        bit [sfm_pkg::HPOS_W-1:0]          hay_pos;
        bit                                hit_seen;
        bit [sfm_pkg::POSITION_BITS-1:0]   hit_start;
        sfm_pkg::out_t                     awaited [$];
        int unsigned                       mismatches;

        function new();
            needle_len    = '0;
            needle_closed = 1'b1;
            mismatches    = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (win[i]) win[i] = '0;
            win_fill  = '0;
            hay_pos   = '0;
            hit_seen  = 1'b0;
            hit_start = '0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task note_item(sfm_pkg::in_t item);
            sfm_pkg::out_t   want;
            longint unsigned pos_now;
            longint unsigned start;
            bit              hit;
            if (item.opcode == sfm_pkg::OP_NEEDLE)
            begin
                // A needle byte always drops the scan in progress. After a
                // closed needle it begins a fresh one, and bytes past the
                // store's depth are dropped.
                clear_scan();
                if (needle_closed)
                begin
                    needle_len    = '0;
                    needle_closed = 1'b0;
                end
                if (needle_len < sfm_pkg::MAX_NEEDLE)
                begin
                    needle[needle_len] = item.data_byte;
                    needle_len++;
                end
                if (item.last)
                    needle_closed = 1'b1;
                return;
            end

            // A haystack byte closes an unfinished needle with what it holds.
            needle_closed = 1'b1;
            for (int i = 0; i < sfm_pkg::MAX_NEEDLE - 1; i++)
                win[i] = win[i + 1];
            win[sfm_pkg::MAX_NEEDLE - 1] = item.data_byte;
            if (win_fill < sfm_pkg::MAX_NEEDLE)
                win_fill++;

            pos_now = hay_pos;
            if (hay_pos < sfm_pkg::POS_SAT)
                hay_pos++;

            // The newest needle_len window bytes must equal the needle.
            hit = (needle_len != 0) && (win_fill >= needle_len);
            for (int i = 0; i < sfm_pkg::MAX_NEEDLE; i++)
                if (hit && i < needle_len
                    && win[sfm_pkg::MAX_NEEDLE - needle_len + i] != needle[i])
                    hit = 1'b0;

            if (!hit_seen && pos_now < sfm_pkg::POS_SAT && hit)
            begin
                start = pos_now + 64'd1 - longint'(needle_len);
                if (start <= sfm_pkg::POS_MAX)
                begin
                    hit_seen  = 1'b1;
                    hit_start = start[sfm_pkg::POSITION_BITS-1:0];
                end
            end

            if (item.last)
            begin
                want.found = hit_seen;
                if (!hit_seen)
                    want.offset = '0;
                else if (longint'(hit_start) > OFFSET_TOP)
                    want.offset = OFFSET_TOP[sfm_pkg::OFFSET_W-1:0];
                else
                    want.offset = sfm_pkg::OFFSET_W'(hit_start);
                awaited.push_back(want);
                clear_scan();
            end
        endtask

        task check_result(sfm_pkg::out_t got);
            sfm_pkg::out_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result found=%0b offset=%0d",
                                 got.found, got.offset));
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report($sformatf("found is %0b, predicted %0b", got.found, want.found));
            if (got.offset !== want.offset)
                report($sformatf("offset is %0d, predicted %0d", got.offset, want.offset));
        endtask

        task close_out();
            if (awaited.size() != 0)
                report($sformatf("%0d predicted results never arrived", awaited.size()));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    sfm_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_ready;
    sfm_pkg::out_t  out_data;

    // Percent chances that the sender idles before a transfer and that the
    // receiver holds off. The main sequence sets them per phase.
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;

    first_match_board board;

    substring_first_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // The receiver draws a fresh ready every cycle. The draw is applied with
    // a nonblocking write, so the block sees a stable value.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Transfers are sampled at the edge that completes them. The values read
    // here are the ones from before the edge, because all drivers and the
    // block's registers update through nonblocking writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_item(in_data);
            if (out_valid && out_ready)
                board.check_result(out_data);
        end
    end

    // This task offers one item and returns once the item has transferred.
    // Valid is lowered only when the sender idles, and never in a step that
    // raises it again.
    task automatic send(sfm_pkg::opcode_t op, sfm_pkg::data_t value, logic is_last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, data_byte: value, last: is_last};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // The sender holds back until every predicted result has been received.
    // The first wait lets the last input transfer reach the tracker.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Short hand-picked sequences: extreme byte values, both opcodes, and the
    // special cases of the search.
    task automatic directed_cases();
        // No needle has been loaded since reset, so the needle is empty and
        // can never match.
        send(sfm_pkg::OP_HAY, 8'h41, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h00, 1'b1);
        // Needle 00 FF. The first haystack has a match at offset 1.
        send(sfm_pkg::OP_NEEDLE, 8'h00, 1'b0);
        send(sfm_pkg::OP_NEEDLE, 8'hFF, 1'b1);
        send(sfm_pkg::OP_HAY, 8'hFF, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h00, 1'b0);
        send(sfm_pkg::OP_HAY, 8'hFF, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h00, 1'b1);
        // The haystack ends after only the first needle byte, so this
        // partial match must not count.
        send(sfm_pkg::OP_HAY, 8'h00, 1'b1);
        // A needle byte in mid-haystack drops the scan without a result. The
        // needle it starts is then ended by the next haystack byte.
        send(sfm_pkg::OP_HAY, 8'h00, 1'b0);
        send(sfm_pkg::OP_HAY, 8'hFF, 1'b0);
        send(sfm_pkg::OP_NEEDLE, 8'h37, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h37, 1'b1);
        // A two-byte needle that is never marked last, with a match at offset 1.
        send(sfm_pkg::OP_NEEDLE, 8'h12, 1'b0);
        send(sfm_pkg::OP_NEEDLE, 8'h34, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h99, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h12, 1'b0);
        send(sfm_pkg::OP_HAY, 8'h34, 1'b1);
    endtask

    // Random traffic. Most of it is a needle followed by a few haystacks,
    // drawn from a small alphabet and often with the needle planted in them,
    // so that matches are common. The rest is loose items of any kind.
    task automatic random_stream(int unsigned quota);
        sfm_pkg::data_t pattern [sfm_pkg::MAX_NEEDLE];
        sfm_pkg::data_t hay_buf [48];
        sfm_pkg::data_t sym [3];
        sfm_pkg::data_t value;
        int unsigned    counted;
        int unsigned    nlen;
        int unsigned    hlen;
        int unsigned    at;
        int unsigned    runs;
        int unsigned    loose;
        bit             open_end;
        counted = 0;
        while (counted < quota)
        begin
            foreach (sym[k])
                sym[k] = sfm_pkg::data_t'($urandom_range(255));
            if ($urandom_range(99) < 80)
            begin
                case ($urandom_range(9))
                    0:       nlen = $urandom_range(sfm_pkg::MAX_NEEDLE + 1,
                                                   sfm_pkg::MAX_NEEDLE + 4);
                    1, 2:    nlen = $urandom_range(7, sfm_pkg::MAX_NEEDLE);
                    default: nlen = $urandom_range(1, 6);
                endcase
                // Some needles are never marked last and are closed by the
                // first haystack byte instead.
                open_end = ($urandom_range(9) == 0);
                for (int k = 0; k < nlen; k++)
                begin
                    value = sym[$urandom_range(2)];
                    if (k < sfm_pkg::MAX_NEEDLE)
                    begin
                        pattern[k] = value;
                        counted++;
                    end
                    send(sfm_pkg::OP_NEEDLE, value, !open_end && (k == nlen - 1));
                end
                if (nlen > sfm_pkg::MAX_NEEDLE)
                    nlen = sfm_pkg::MAX_NEEDLE;
                runs = $urandom_range(1, 3);
                repeat (runs)
                begin
                    hlen = ($urandom_range(3) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
                    for (int k = 0; k < hlen; k++)
                        hay_buf[k] = ($urandom_range(7) == 0)
                                   ? sfm_pkg::data_t'($urandom_range(255))
                                   : sym[$urandom_range(2)];
                    // A planted copy may run past the end, which leaves a
                    // partial match that must not count.
                    if ($urandom_range(1) == 1)
                    begin
                        at = $urandom_range(0, hlen - 1);
                        for (int k = 0; k < nlen; k++)
                            if (at + k < hlen)
                                hay_buf[at + k] = pattern[k];
                    end
                    for (int k = 0; k < hlen; k++)
                        send(sfm_pkg::OP_HAY, hay_buf[k], k == hlen - 1);
                    counted += hlen;
                end
            end
            else
            begin
                loose = $urandom_range(1, 8);
                repeat (loose)
                    send(sfm_pkg::opcode_t'($urandom_range(1)),
                         sfm_pkg::data_t'($urandom_range(255)),
                         $urandom_range(3) == 0);
                counted += loose;
            end
        end
    endtask

    // If the run has not finished by this fixed time, it is ended as failed.
    initial
    begin
        #200_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1 has no idling on either side. It carries the directed
        // cases.
        directed_cases();
        random_stream(150);
        wait_for_results();

        // Phase 2: the sender idles about half the cycles.
        sender_idle_pct = 50;
        random_stream(150);
        wait_for_results();

        // Phase 3: the receiver stalls about half the cycles.
        sender_idle_pct    = 0;
        receiver_stall_pct = 50;
        random_stream(150);
        wait_for_results();

        // Phase 4: both sides hold off at random.
        sender_idle_pct    = 37;
        receiver_stall_pct = 37;
        random_stream(150);
        wait_for_results();

        // Leave time for any stray result to show up.
        repeat (8) @(posedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfm_pkg.sv
rtl/sfm_needle.sv
rtl/sfm_scan.sv
rtl/substring_first_match.sv
dv/tb_substring_first_match.sv
